// ===== sv/rlpsd_pkg.sv =====
// Shared types, constants and command codes for the RGB LED panel scan driver.
// Depends on nothing; every other file of the block imports it.
package rlpsd_pkg;

   // Panel geometry.
   localparam int PANEL_ROWS    = 64;
   localparam int PANEL_COLUMNS = 64;
   localparam int HALF_ROWS     = PANEL_ROWS / 2;
   localparam int ROW_AW        = $clog2(PANEL_ROWS);
   localparam int WORD_W        = 64;
   localparam int COL_W         = 6;
   localparam int NUM_PLANES    = 3;

   localparam logic [WORD_W-1:0] COLUMN_MASK =
      {WORD_W{1'b1}} >> (WORD_W - PANEL_COLUMNS);

   // Command queue between the front and back ends.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Plane positions in a color mask and in a stored row.
   localparam int MASK_BLUE  = 0;
   localparam int MASK_GREEN = 1;
   localparam int MASK_RED   = 2;

   // Raw plane codes carried by plane_select.
   localparam logic [1:0] PLANE_RED   = 2'd0;
   localparam logic [1:0] PLANE_GREEN = 2'd1;
   localparam logic [1:0] PLANE_BLUE  = 2'd2;

   typedef enum logic [2:0] {
      REQ_SET_PIXEL   = 3'd0,
      REQ_CLEAR_PIXEL = 3'd1,
      REQ_ROW_MASK    = 3'd2,
      REQ_ROW_RAW     = 3'd3,
      REQ_FILL        = 3'd4,
      REQ_WIPE        = 3'd5,
      REQ_SCAN        = 3'd6
   } req_code_type;

   typedef enum logic [2:0] {
      OP_SET,
      OP_CLEAR,
      OP_ROW,
      OP_FILL,
      OP_WIPE,
      OP_SCAN
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PIX_READ,
      ST_PIX_WRITE,
      ST_ROW,
      ST_FILL,
      ST_WIPE,
      ST_READ_TOP,
      ST_READ_BOTTOM,
      ST_SHIFT
   } back_state_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [5:0]  row_index;
      logic [5:0]  column_index;
      logic [2:0]  color_mask;
      logic [1:0]  plane_select;
      logic [63:0] row_bits;
   } req_item_type;

   typedef struct packed {
      logic [4:0] row_select;
      logic [5:0] beat_column;
      logic       top_red;
      logic       top_green;
      logic       top_blue;
      logic       bottom_red;
      logic       bottom_green;
      logic       bottom_blue;
      logic       last_beat;
   } rsp_item_type;

   typedef struct packed {
      op_type                  op;
      logic [ROW_AW-1:0]       row;
      logic [COL_W-1:0]        column;
      logic [NUM_PLANES-1:0]   planes;
      logic [WORD_W-1:0]       bits;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== sv/rlpsd_front.sv =====
// Front end: decodes a request into a queued command and drops requests that
// change nothing. Depends on rlpsd_pkg.
module rlpsd_front (
   input  rlpsd_pkg::req_item_type req_item,
   output rlpsd_pkg::cmd_type      cmd,
   output logic                    keep
);
   import rlpsd_pkg::*;

   logic row_ok;
   logic col_ok;
   logic mask_any;

   assign row_ok   = {1'b0, req_item.row_index} < 7'(PANEL_ROWS);
   assign col_ok   = {1'b0, req_item.column_index} < 7'(PANEL_COLUMNS);
   assign mask_any = |req_item.color_mask;

   always_comb begin
      cmd.op     = OP_SCAN;
      cmd.row    = req_item.row_index[ROW_AW-1:0];
      cmd.column = req_item.column_index;
      cmd.planes = req_item.color_mask;
      cmd.bits   = req_item.row_bits & COLUMN_MASK;
      keep       = 1'b0;
      unique case (req_item.req_type)
         REQ_SET_PIXEL: begin
            cmd.op = OP_SET;
            keep   = row_ok && col_ok && mask_any;
         end
         REQ_CLEAR_PIXEL: begin
            cmd.op     = OP_CLEAR;
            cmd.planes = '1;
            keep       = row_ok && col_ok;
         end
         REQ_ROW_MASK: begin
            cmd.op = OP_ROW;
            keep   = row_ok && mask_any;
         end
         REQ_ROW_RAW: begin
            cmd.op     = OP_ROW;
            cmd.planes = '0;
            case (req_item.plane_select)
               PLANE_RED:   cmd.planes[MASK_RED]   = 1'b1;
               PLANE_GREEN: cmd.planes[MASK_GREEN] = 1'b1;
               PLANE_BLUE:  cmd.planes[MASK_BLUE]  = 1'b1;
               default:     cmd.planes = '0;
            endcase
            keep = row_ok && (|cmd.planes);
         end
         REQ_FILL: begin
            cmd.op = OP_FILL;
            keep   = mask_any;
         end
         REQ_WIPE: begin
            cmd.op = OP_WIPE;
            keep   = 1'b1;
         end
         REQ_SCAN: begin
            cmd.op = OP_SCAN;
            keep   = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

endmodule

// ===== sv/rlpsd_queue.sv =====
// Short FIFO of decoded commands between the front and back ends.
// Depends on rlpsd_pkg.
module rlpsd_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  rlpsd_pkg::cmd_type          push_cmd,
   input  logic                        pop,
   output rlpsd_pkg::cmd_type          head_cmd,
   output rlpsd_pkg::queue_status_type status
);
   import rlpsd_pkg::*;

   cmd_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_cmd     = entries_ff[rd_ptr_ff];
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/rlpsd_back.sv =====
// Back end: owns the frame buffer memory, carries out queued commands and
// shifts out scan beats. Depends on rlpsd_pkg.
module rlpsd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  rlpsd_pkg::cmd_type          head_cmd,
   input  rlpsd_pkg::queue_status_type q_status,
   output logic                        pop,
   output logic                        rsp_strobe,
   output rlpsd_pkg::rsp_item_type     rsp_item
);
   import rlpsd_pkg::*;

   // Frame buffer: one row per entry, three planes per row.
   logic [NUM_PLANES-1:0][WORD_W-1:0] plane_mem [PANEL_ROWS];

   // An entry whose valid bit is clear reads as zero (reset and wipe).
   logic [NUM_PLANES-1:0] valid_ff [PANEL_ROWS];

   back_state_type                    state_ff, state_in;
   cmd_type                           cmd_ff, cmd_in;
   logic [COL_W-1:0]                  cnt_ff, cnt_in;
   logic [ROW_AW-1:0]                 scan_ff, scan_in;
   logic [NUM_PLANES-1:0][WORD_W-1:0] top_ff, top_in;
   logic [NUM_PLANES-1:0][WORD_W-1:0] rdata_ff;
   logic [NUM_PLANES-1:0]             rvalid_ff;
   logic [NUM_PLANES-1:0][WORD_W-1:0] rdata_eff;
   rsp_item_type                      rsp_ff, rsp_in;
   logic                              strobe_ff, strobe_in;

   logic                              rd_en;
   logic [ROW_AW-1:0]                 rd_addr;
   logic                              wr_en;
   logic [ROW_AW-1:0]                 wr_addr;
   logic [NUM_PLANES-1:0]             wr_planes;
   logic [NUM_PLANES-1:0][WORD_W-1:0] wr_data;
   logic                              wipe;
   logic [WORD_W-1:0]                 pixel_bit;

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;
   assign pixel_bit  = WORD_W'(1) << cmd_ff.column;

   always_comb begin
      for (int p = 0; p < NUM_PLANES; p++) begin
         rdata_eff[p] = rdata_ff[p] & {WORD_W{rvalid_ff[p]}};
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               unique case (head_cmd.op)
                  OP_SET, OP_CLEAR: state_in = ST_PIX_READ;
                  OP_ROW:           state_in = ST_ROW;
                  OP_FILL:          state_in = ST_FILL;
                  OP_WIPE:          state_in = ST_WIPE;
                  OP_SCAN:          state_in = ST_READ_TOP;
                  default:          state_in = ST_IDLE;
               endcase
            end
         end
         ST_PIX_READ:    state_in = ST_PIX_WRITE;
         ST_PIX_WRITE:   state_in = ST_IDLE;
         ST_ROW:         state_in = ST_IDLE;
         ST_WIPE:        state_in = ST_IDLE;
         ST_FILL: begin
            if (cnt_ff == COL_W'(PANEL_ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ_TOP:    state_in = ST_READ_BOTTOM;
         ST_READ_BOTTOM: state_in = ST_SHIFT;
         ST_SHIFT: begin
            if (cnt_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default:        state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      pop       = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = cmd_ff.row;
      wr_en     = 1'b0;
      wr_addr   = cmd_ff.row;
      wr_planes = cmd_ff.planes;
      wr_data   = {NUM_PLANES{cmd_ff.bits}};
      wipe      = 1'b0;
      cmd_in    = cmd_ff;
      cnt_in    = cnt_ff;
      scan_in   = scan_ff;
      top_in    = top_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop    = 1'b1;
               cmd_in = head_cmd;
               cnt_in = (head_cmd.op == OP_SCAN) ? COL_W'(PANEL_COLUMNS - 1) : '0;
            end
         end
         ST_PIX_READ: begin
            rd_en = 1'b1;
         end
         ST_PIX_WRITE: begin
            // Read-modify-write; untouched planes are written back unchanged.
            wr_en     = 1'b1;
            wr_planes = '1;
            for (int p = 0; p < NUM_PLANES; p++) begin
               if (cmd_ff.op == OP_SET) begin
                  wr_data[p] = cmd_ff.planes[p] ? (rdata_eff[p] | pixel_bit)
                                                : rdata_eff[p];
               end else begin
                  wr_data[p] = rdata_eff[p] & ~pixel_bit;
               end
            end
         end
         ST_ROW: begin
            wr_en = 1'b1;
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[ROW_AW-1:0];
            cnt_in  = cnt_ff + 1'b1;
         end
         ST_WIPE: begin
            wipe = 1'b1;
         end
         ST_READ_TOP: begin
            rd_en   = 1'b1;
            rd_addr = scan_ff;
         end
         ST_READ_BOTTOM: begin
            rd_en   = 1'b1;
            rd_addr = scan_ff + ROW_AW'(HALF_ROWS);
            top_in  = rdata_eff;
         end
         ST_SHIFT: begin
            strobe_in           = 1'b1;
            rsp_in.row_select   = 5'(scan_ff);
            rsp_in.beat_column  = cnt_ff;
            rsp_in.top_red      = top_ff[MASK_RED][cnt_ff];
            rsp_in.top_green    = top_ff[MASK_GREEN][cnt_ff];
            rsp_in.top_blue     = top_ff[MASK_BLUE][cnt_ff];
            rsp_in.bottom_red   = rdata_eff[MASK_RED][cnt_ff];
            rsp_in.bottom_green = rdata_eff[MASK_GREEN][cnt_ff];
            rsp_in.bottom_blue  = rdata_eff[MASK_BLUE][cnt_ff];
            rsp_in.last_beat    = (cnt_ff == '0);
            cnt_in              = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               scan_in = (scan_ff == ROW_AW'(HALF_ROWS - 1)) ? '0 : scan_ff + 1'b1;
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         scan_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         scan_ff   <= scan_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      cnt_ff <= cnt_in;
      top_ff <= top_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset || wipe) begin
         for (int r = 0; r < PANEL_ROWS; r++) begin
            valid_ff[r] <= '0;
         end
      end else if (wr_en) begin
         valid_ff[wr_addr] <= valid_ff[wr_addr] | wr_planes;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rvalid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            if (wr_planes[p]) begin
               plane_mem[wr_addr][p] <= wr_data[p];
            end
         end
      end
      if (rd_en) begin
         rdata_ff <= plane_mem[rd_addr];
      end
   end

endmodule

// ===== sv/rgb_led_panel_scan_driver.sv =====
// Top level of the RGB LED panel scan driver: front-end decoder, command queue
// and back end with the frame buffer. Depends on rlpsd_pkg and its submodules.
//
//   Channel    Ports                       Handshake
//   request    start, busy, req_item       taken when start is high and busy is low
//   response   rsp_strobe, rsp_item        one beat per strobe cycle, never held off
//
// A scan in the back end dequeues, does two memory reads for the row pair, then
// shifts out one beat per column. A fill writes one row per write, pixel writes
// read the row and write it back, a row write is a single write and a wipe
// clears the valid bits. The frame buffer is never read and written in one state.
// Two commands can wait in the queue; busy is high while the queue is full.
// Reset clears the frame buffer at once through per-row valid bits.
module rgb_led_panel_scan_driver (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  rlpsd_pkg::req_item_type req_item,
   output logic                    rsp_strobe,
   output rlpsd_pkg::rsp_item_type rsp_item
);
   import rlpsd_pkg::*;

   cmd_type          front_cmd;
   logic             front_keep;
   cmd_type          head_cmd;
   queue_status_type q_status;
   logic             pop;
   logic             push;

   assign busy = q_status.full;
   assign push = start && !busy && front_keep;

   rlpsd_front u_front (
      .req_item (req_item),
      .cmd      (front_cmd),
      .keep     (front_keep)
   );

   rlpsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (front_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   rlpsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

// ===== sv/rlpsd_checker.sv =====
// Port-level checks on the scan beat stream, bound to the top level.
// Depends on rlpsd_pkg.
module rlpsd_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_strobe,
   input rlpsd_pkg::rsp_item_type rsp_item
);
   import rlpsd_pkg::*;

   // The latch mark comes exactly on column zero.
   a_last_on_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.last_beat == (rsp_item.beat_column == '0)))
      else $error("last_beat does not match column zero");

   // Within a row the beats are back to back, counting down, on one row pair.
   a_count_down: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last_beat |=>
         rsp_strobe && (rsp_item.beat_column == $past(rsp_item.beat_column) - 1'b1)
         && (rsp_item.row_select == $past(rsp_item.row_select)))
      else $error("scan beats not contiguous within a row");

   // A row always starts at the highest column.
   a_first_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !$past(rsp_strobe) |->
         (rsp_item.beat_column == 6'(PANEL_COLUMNS - 1)))
      else $error("row did not start at the highest column");

   // The back end needs a dequeue and two reads before the next row.
   a_gap_after_latch: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.last_beat |=> !rsp_strobe)
      else $error("beat right after the latch mark");

   // Row pair addresses stay in the upper half.
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ({1'b0, rsp_item.row_select} < 6'(HALF_ROWS)))
      else $error("row pair address out of range");

endmodule

bind rgb_led_panel_scan_driver rlpsd_checker u_rlpsd_checker (.*);
